// File: rtl/avt_pkg.sv
// Package for the affine vector transform unit: widths, register indexes,
// reset values and the payload types passed between the pipeline stages.
// Depends on nothing; every other file imports it.
package avt_pkg;

  localparam int unsigned VEC_W      = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned PROD_W     = VEC_W + COEF_W;
  localparam int unsigned SUM_W      = PROD_W + 2;
  localparam int unsigned SHIFT      = 12;
  localparam int unsigned SHR_W      = SUM_W - SHIFT;
  localparam int unsigned TOT_W      = SHR_W + 1;
  localparam int unsigned DIMS       = 3;
  localparam int unsigned ROW_W      = DIMS * COEF_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = ROW_W;

  localparam logic [ROW_W-1:0] ROW0_RESET = 48'h0000_0000_1000;
  localparam logic [ROW_W-1:0] ROW1_RESET = 48'h0000_1000_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 48'h1000_0000_0000;

  localparam logic [VEC_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [VEC_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0  = 3'd0,
    REG_ROW1  = 3'd1,
    REG_ROW2  = 3'd2,
    REG_TRANS_X = 3'd3,
    REG_TRANS_Y = 3'd4,
    REG_TRANS_Z = 3'd5,
    REG_SKIP  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [DIMS-1:0][ROW_W-1:0] row;
    logic [DIMS-1:0][VEC_W-1:0] trans;
    logic                       skip;
  } cfg_t;

  typedef struct packed {
    logic [DIMS-1:0][VEC_W-1:0] vec;
    logic                       last;
  } vec_req_t;

  typedef struct packed {
    logic [DIMS-1:0][DIMS-1:0][PROD_W-1:0] prod;
    logic                                  last;
  } prod_req_t;

  typedef struct packed {
    logic [DIMS-1:0][SHR_W-1:0] shr;
    logic                       last;
  } sum_req_t;

  typedef struct packed {
    logic [DIMS-1:0][VEC_W-1:0] comp;
    logic                       overflow;
    logic                       last;
  } res_req_t;

endpackage

// File: rtl/avt_mul_stage.sv
// First pipeline stage: the nine matrix-entry by component products.
// Depends on avt_pkg.
module avt_mul_stage import avt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  vec_req_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_req_t out_data
);

  logic signed [COEF_W-1:0] coef [DIMS][DIMS];
  logic signed [VEC_W-1:0]  comp [DIMS];
  logic signed [PROD_W-1:0] prod [DIMS][DIMS];
  logic                     valid;

  always_comb begin
    for (int r = 0; r < DIMS; r++) begin
      comp[r] = in_data.vec[r];
      for (int c = 0; c < DIMS; c++) begin
        coef[r][c] = cfg.row[r][c*COEF_W +: COEF_W];
      end
    end
    for (int r = 0; r < DIMS; r++) begin
      for (int c = 0; c < DIMS; c++) begin
        prod[r][c] = PROD_W'(coef[r][c]) * PROD_W'(comp[c]);
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < DIMS; r++) begin
        for (int c = 0; c < DIMS; c++) begin
          out_data.prod[r][c] <= prod[r][c];
        end
      end
      out_data.last <= in_data.last;
    end
  end

endmodule

// File: rtl/avt_sum_stage.sv
// Second pipeline stage: sums the three products of each row and takes
// the floor of the sum divided by 4096. Depends on avt_pkg.
module avt_sum_stage import avt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_req_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output sum_req_t  out_data
);

  logic signed [PROD_W-1:0] prod [DIMS][DIMS];
  logic signed [SUM_W-1:0]  sum  [DIMS];
  logic                     valid;

  always_comb begin
    for (int r = 0; r < DIMS; r++) begin
      for (int c = 0; c < DIMS; c++) begin
        prod[r][c] = in_data.prod[r][c];
      end
    end
    for (int r = 0; r < DIMS; r++) begin
      sum[r] = SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]) + SUM_W'(prod[r][2]);
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Dropping the low twelve bits of a two's complement sum floors it.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int r = 0; r < DIMS; r++) begin
        out_data.shr[r] <= sum[r][SUM_W-1:SHIFT];
      end
      out_data.last <= in_data.last;
    end
  end

endmodule

// File: rtl/avt_sat_stage.sv
// Third pipeline stage and output register: adds the translation, saturates
// each component to 32 bits and raises the overflow flag. Depends on avt_pkg.
module avt_sat_stage import avt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  sum_req_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output res_req_t out_data
);

  logic signed [SHR_W-1:0] shr   [DIMS];
  logic signed [VEC_W-1:0] trans [DIMS];
  logic signed [TOT_W-1:0] tot   [DIMS];
  logic [DIMS-1:0]         sat;
  logic [DIMS-1:0][VEC_W-1:0] comp;
  logic                    valid;

  always_comb begin
    for (int r = 0; r < DIMS; r++) begin
      shr[r]   = in_data.shr[r];
      trans[r] = cfg.skip ? '0 : cfg.trans[r];
      tot[r]   = TOT_W'(shr[r]) + TOT_W'(trans[r]);
      sat[r]   = (tot[r][TOT_W-1:VEC_W-1] != '0) && (tot[r][TOT_W-1:VEC_W-1] != '1);
      if (sat[r]) begin
        comp[r] = tot[r][TOT_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
        comp[r] = tot[r][VEC_W-1:0];
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data.comp     <= comp;
      out_data.overflow <= |sat;
      out_data.last     <= in_data.last;
    end
  end

endmodule

// File: rtl/affine_vector_transform_unit.sv
// Top level of the affine vector transform unit: configuration registers
// and the three-stage multiply, sum and saturate pipeline.
// Depends on avt_pkg, avt_mul_stage, avt_sum_stage and avt_sat_stage.
//
//   Channel  Direction  Signals                                 Carries
//   s_*      in         s_tvalid s_tready s_tdata s_tlast       vector, last marker
//   m_*      out        m_tvalid m_tready m_tdata m_tuser m_tlast  result, overflow, last
//   cfg_*    in         cfg_we cfg_index cfg_data               register write
//
// One request is taken per cycle while s_tready is high; its result passes
// through one register each for the products, the row sums and the saturation.
// A stall on the output holds only the stages that are full: an empty stage
// still takes a request, so s_tready follows m_tready through the stages.
// Synchronous reset empties the pipeline and restores the identity matrix.
module affine_vector_transform_unit import avt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [3*VEC_W-1:0]    s_tdata,   // vec_x, vec_y, vec_z
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [3*VEC_W-1:0]    m_tdata,   // out_x, out_y, out_z
  output logic                  m_tuser,   // overflow
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  vec_req_t  vec_req;
  prod_req_t prod_req;
  sum_req_t  sum_req;
  res_req_t  res_req;
  logic      prod_valid;
  logic      prod_ready;
  logic      sum_valid;
  logic      sum_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0]   <= ROW0_RESET;
      cfg.row[1]   <= ROW1_RESET;
      cfg.row[2]   <= ROW2_RESET;
      cfg.trans[0] <= '0;
      cfg.trans[1] <= '0;
      cfg.trans[2] <= '0;
      cfg.skip     <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ROW0:    cfg.row[0]   <= cfg_data;
        REG_ROW1:    cfg.row[1]   <= cfg_data;
        REG_ROW2:    cfg.row[2]   <= cfg_data;
        REG_TRANS_X: cfg.trans[0] <= cfg_data[VEC_W-1:0];
        REG_TRANS_Y: cfg.trans[1] <= cfg_data[VEC_W-1:0];
        REG_TRANS_Z: cfg.trans[2] <= cfg_data[VEC_W-1:0];
        REG_SKIP:    cfg.skip     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < DIMS; r++) begin
      vec_req.vec[r] = s_tdata[r*VEC_W +: VEC_W];
    end
    vec_req.last = s_tlast;
  end

  avt_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (vec_req),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_req)
  );

  avt_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_req),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum_req)
  );

  avt_sat_stage u_sat (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sum_req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_req)
  );

  always_comb begin
    for (int r = 0; r < DIMS; r++) begin
      m_tdata[r*VEC_W +: VEC_W] = res_req.comp[r];
    end
  end

  assign m_tuser = res_req.overflow;
  assign m_tlast = res_req.last;

  // The pipeline is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // An empty output stage lets every stage behind it take a request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while the output stage is empty");

  // A flagged result carries at least one saturated component.
  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (res_req.comp[0] == WORD_MAX || res_req.comp[0] == WORD_MIN ||
       res_req.comp[1] == WORD_MAX || res_req.comp[1] == WORD_MIN ||
       res_req.comp[2] == WORD_MAX || res_req.comp[2] == WORD_MIN))
    else $error("overflow flagged without a saturated component");

endmodule
